// ----- design/apa_pkg.sv -----
// Shared constants and types for the average precision accumulator.
package apa_pkg;

  localparam int CNT_W     = 13;   // rank and relevant counters
  localparam int SUM_W     = 44;   // Q12.32 precision sum
  localparam int GRADE_W   = 8;
  localparam int TOTAL_W   = 16;
  localparam int AP_W      = 17;   // Q0.16 with room for 1.0
  localparam int REM_W     = 16;   // divider remainder / divisor
  localparam int QUO_W     = 33;   // divider quotient / numerator
  localparam int STEP_W    = 6;
  localparam int DIV_STEPS = 33;

  localparam logic [CNT_W-1:0]  MAX_RANKED = CNT_W'(4096);
  localparam logic [AP_W-1:0]   ONE_Q16    = AP_W'(65536);
  localparam logic [SUM_W-1:0]  SUM_MAX    = {SUM_W{1'b1}};
  localparam logic [STEP_W-1:0] LAST_STEP  = STEP_W'(DIV_STEPS - 1);

  // Request to the shared shift-subtract divider.
  typedef struct packed {
    logic             start;
    logic [REM_W-1:0] rem;      // partial remainder preload, below divisor
    logic [QUO_W-1:0] num;      // numerator bits, shifted in MSB first
    logic [REM_W-1:0] divisor;
  } div_req_t;

endpackage

// ----- design/apa_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle.
module apa_div (
  input  logic              clk,
  input  logic              rst_n,
  input  apa_pkg::div_req_t req,
  output logic              done,
  output logic [32:0]       quotient
);
  import apa_pkg::*;

  logic [REM_W-1:0]  rem_r, rem_nxt;
  logic [QUO_W-1:0]  num_r, num_nxt;
  logic [REM_W-1:0]  div_r;
  logic [STEP_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [REM_W:0]    trial;
  logic [REM_W:0]    diff;
  logic              ge;

  // trial remainder: shift in next numerator bit
  assign trial = {rem_r, num_r[QUO_W-1]};
  assign ge    = trial >= {1'b0, div_r};
  assign diff  = trial - {1'b0, div_r};

  always_comb begin
    rem_nxt = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
    num_nxt = {num_r[QUO_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= LAST_STEP;
      end else if (busy_r) begin
        cnt_r <= cnt_r - STEP_W'(1);
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.rem;
      num_r <= req.num;
      div_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      num_r <= num_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = num_r;

endmodule

// ----- design/average_precision_accumulator.sv -----
// Top level of the average precision accumulator.
//
// Input stream: one transaction per retrieved document, in rank order.
//   in_tdata carries the signed relevance grade and the topic's total
//   relevant count; in_tlast marks the last document of a ranking.
// Output stream: one transaction per ranking, sent after the last document.
//   out_tdata is average precision in Q0.16 (65536 = 1.0); out_tuser holds
//   the defined and saturated flags.
// Config: cfg_wr_en / cfg_wr_data write the signed relevance threshold
//   (reset value 1); write only while the block is idle.
// Sequence: a non-relevant document is taken while idle and the block stays
//   idle; a relevant one runs the serial divider for the precision at its
//   rank and then adds it to the sum. The last document then picks the
//   result path, divides the sum by the total relevant count and loads the
//   output register; an undefined or clamped result skips the division.
//   in_tready is low meanwhile.
// Reset (synchronous, active low) clears the counters, the sum, the output
//   valid and restores the threshold. When the receiver stalls, the result
//   is held in the output register; the next ranking's documents are still
//   accepted, but its result waits until that one is taken, with in_tready low.
module average_precision_accumulator (
  input  logic        clk,
  input  logic        rst_n,
  // config
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,     // relevance_threshold
  // document stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,        // [7:0] relevance_grade, [23:8] total_relevant
  input  logic        in_tlast,        // last_in_ranking
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,       // [16:0] average_precision, [23:17] zero
  output logic [1:0]  out_tuser        // [0] result_defined, [1] saturated
);
  import apa_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;  // wait for a document
  localparam logic [2:0] ST_DIV  = 3'd1;  // precision at this rank
  localparam logic [2:0] ST_FIN  = 3'd2;  // end of ranking, pick result path
  localparam logic [2:0] ST_FDIV = 3'd3;  // sum / total
  localparam logic [2:0] ST_OUT  = 3'd4;  // hand result to output register

  logic [2:0]         state_r, state_nxt;
  logic [GRADE_W-1:0] thr_r;
  logic [CNT_W-1:0]   rank_r, found_r;
  logic [SUM_W-1:0]   sum_r;
  logic               last_r;
  logic [TOTAL_W-1:0] total_r;
  logic [AP_W-1:0]    res_ap_r;
  logic               res_def_r, res_sat_r;
  logic               out_tvalid_r;
  logic [AP_W-1:0]    out_ap_r;
  logic               out_def_r, out_sat_r;

  logic [GRADE_W-1:0] grade;
  logic               accept, take, relevant;
  logic [CNT_W-1:0]   rank_inc, found_inc;
  div_req_t           div_req;
  logic               div_done;
  logic [QUO_W-1:0]   quotient;
  logic [SUM_W:0]     sum_add;
  logic [SUM_W-1:0]   sum_sat;
  logic               total_short;
  logic               out_load;

  assign grade     = in_tdata[GRADE_W-1:0];
  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  // documents past the ranking limit are neither counted nor scored
  assign take      = rank_r < MAX_RANKED;
  assign relevant  = $signed(grade) >= $signed(thr_r);
  assign rank_inc  = rank_r + CNT_W'(1);
  assign found_inc = found_r + CNT_W'(1);

  assign sum_add     = {1'b0, sum_r} + {{(SUM_W + 1 - QUO_W){1'b0}}, quotient};
  assign sum_sat     = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
  assign total_short = {{(TOTAL_W - CNT_W){1'b0}}, found_r} > total_r;
  assign out_load    = (state_r == ST_OUT) && (!out_tvalid_r || out_tready);

  apa_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .done     (div_done),
    .quotient (quotient)
  );

  // Sequencer and divider requests
  always_comb begin
    state_nxt       = state_r;
    div_req.start   = 1'b0;
    div_req.rem     = '0;
    div_req.num     = '0;
    div_req.divisor = '0;
    unique case (state_r)
      ST_IDLE: begin
        // found << 32 / rank: preload found >> 1, stream its LSB then 32 zeros
        div_req.rem     = {{(REM_W - CNT_W + 1){1'b0}}, found_inc[CNT_W-1:1]};
        div_req.num     = {found_inc[0], {(QUO_W - 1){1'b0}}};
        div_req.divisor = {{(REM_W - CNT_W){1'b0}}, rank_inc};
        if (accept) begin
          if (take && relevant) begin
            div_req.start = 1'b1;
            state_nxt     = ST_DIV;
          end else if (in_tlast) begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_DIV: begin
        if (div_done) state_nxt = last_r ? ST_FIN : ST_IDLE;
      end
      ST_FIN: begin
        // sum / (total << 16) == (sum >> 16) / total
        div_req.rem     = '0;
        div_req.num     = {{(QUO_W - SUM_W + 16){1'b0}}, sum_r[SUM_W-1:16]};
        div_req.divisor = total_r;
        if (found_r == '0 || total_short) begin
          state_nxt = ST_OUT;
        end else begin
          div_req.start = 1'b1;
          state_nxt     = ST_FDIV;
        end
      end
      ST_FDIV: begin
        if (div_done) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      thr_r        <= GRADE_W'(1);
      rank_r       <= '0;
      found_r      <= '0;
      sum_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) thr_r <= cfg_wr_data;

      if (accept && take) begin
        rank_r <= rank_inc;
        if (relevant) found_r <= found_inc;
      end
      if (state_r == ST_DIV && div_done) sum_r <= sum_sat;

      if (out_load) begin
        out_tvalid_r <= 1'b1;
        // next topic starts clean
        rank_r  <= '0;
        found_r <= '0;
        sum_r   <= '0;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      last_r  <= in_tlast;
      total_r <= in_tdata[GRADE_W +: TOTAL_W];
    end
    if (state_r == ST_FIN) begin
      if (found_r == '0) begin
        res_ap_r  <= '0;
        res_def_r <= 1'b0;
        res_sat_r <= 1'b0;
      end else begin
        // total below found: clamp to 1.0 and flag
        res_ap_r  <= ONE_Q16;
        res_def_r <= 1'b1;
        res_sat_r <= 1'b1;
      end
    end
    if (state_r == ST_FDIV && div_done) begin
      res_ap_r  <= (quotient > {{(QUO_W - AP_W){1'b0}}, ONE_Q16}) ?
                   ONE_Q16 : quotient[AP_W-1:0];
      res_def_r <= 1'b1;
      res_sat_r <= 1'b0;
    end
    if (out_load) begin
      out_ap_r  <= res_ap_r;
      out_def_r <= res_def_r;
      out_sat_r <= res_sat_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(24 - AP_W){1'b0}}, out_ap_r};
  assign out_tuser  = {out_sat_r, out_def_r};

endmodule

// ----- design/apa_checker.sv -----
// Port-level checks for the average precision accumulator, bound to the top.
module apa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // reset empties the output register
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

  // a saturated result is defined and clamped to 1.0
  a_sat_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tuser[0] && out_tdata == 24'd65536)
    else $error("saturated result not 1.0");

  // an undefined result is zero and not saturated
  a_undef_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == 24'd0 && !out_tuser[1])
    else $error("undefined result not zero");

  // average precision never exceeds 1.0
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata <= 24'd65536)
    else $error("average precision above 1.0");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

endmodule

bind average_precision_accumulator apa_checker u_apa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ----- dv/testbench.sv -----
// Self-checking stream testbench for the average precision accumulator.
`timescale 1ns / 100ps

module testbench;
  import apa_pkg::*;

  localparam int DRAIN_CYCLES = 100;  // > one relevant doc plus the final division

  typedef struct {
    logic signed [GRADE_W-1:0] grade;
    logic                      last;
    logic [TOTAL_W-1:0]        total;
    int unsigned               gap;    // idle cycles after this transaction
  } doc_t;

  typedef struct packed {
    logic [AP_W-1:0] avg_prec;
    logic            defined;
    logic            saturated;
  } ap_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [7:0]  cfg_wr_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // [7:0] relevance_grade, [23:8] total_relevant
  logic        in_tlast = 1'b0; // last_in_ranking
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;       // [16:0] average_precision, [23:17] zero
  logic [1:0]  out_tuser;       // [0] result_defined, [1] saturated

  doc_t       doc_queue[$];
  ap_result_t ap_expected[$];
  int         fail_count = 0;

  // predictor state
  logic signed [GRADE_W-1:0] relevance_thr = 8'sd1;
  logic [CNT_W-1:0]          rank_cnt = '0;
  logic [CNT_W-1:0]          rel_cnt = '0;
  logic [SUM_W-1:0]          prec_sum = '0;

  // stimulus-side view of the threshold, used to shape grades and totals
  logic signed [GRADE_W-1:0] gen_thr = 8'sd1;

  doc_t        cur_doc;
  int unsigned src_wait = 0;
  int unsigned sink_wait = 0;
  logic        sink_burst = 1'b0;

  average_precision_accumulator DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #6 clk = ~clk;

  // Update running AP state for one accepted document; queue a result on the last one.
  task automatic score_document(input doc_t d);
    logic [63:0] term;
    logic [63:0] sum_next;
    logic [63:0] ap_q;
    ap_result_t  r;
    if (rank_cnt < MAX_RANKED) begin
      rank_cnt = rank_cnt + 1'b1;
      if (d.grade >= relevance_thr) begin
        rel_cnt  = rel_cnt + 1'b1;
        term     = (64'(rel_cnt) << 32) / 64'(rank_cnt);
        sum_next = 64'(prec_sum) + term;
        prec_sum = (sum_next > 64'(SUM_MAX)) ? SUM_MAX : sum_next[SUM_W-1:0];
      end
    end
    if (d.last) begin
      if (rel_cnt == '0) begin
        r = '{avg_prec: '0, defined: 1'b0, saturated: 1'b0};
      end else if (32'(d.total) < 32'(rel_cnt)) begin
        r = '{avg_prec: ONE_Q16, defined: 1'b1, saturated: 1'b1};
      end else begin
        ap_q = 64'(prec_sum) / (64'(d.total) << 16);
        if (ap_q > 64'(ONE_Q16)) ap_q = 64'(ONE_Q16);
        r = '{avg_prec: ap_q[AP_W-1:0], defined: 1'b1, saturated: 1'b0};
      end
      ap_expected.push_back(r);
      rank_cnt = '0;
      rel_cnt  = '0;
      prec_sum = '0;
    end
  endtask

  function automatic logic signed [GRADE_W-1:0] pick_grade(input logic signed [GRADE_W-1:0] thr);
    int v;
    if ($urandom_range(0, 2) == 0) return GRADE_W'($urandom);
    v = int'(thr) + int'($urandom_range(0, 4)) - 2;
    if (v > 127) v = 127;
    if (v < -128) v = -128;
    return GRADE_W'(v);
  endfunction

  task automatic push_doc(input logic signed [GRADE_W-1:0] g, input logic l,
                          input logic [TOTAL_W-1:0] t, input int unsigned gap_max);
    doc_t d;
    d.grade = g;
    d.last  = l;
    d.total = t;
    d.gap   = $urandom_range(0, gap_max);
    doc_queue.push_back(d);
  endtask

  // One complete ranking with random grades; the total on the last document
  // is steered around the relevant count the block will find.
  task automatic add_ranking(input int len, input int unsigned gap_max);
    int                        found;
    logic signed [GRADE_W-1:0] g;
    logic [TOTAL_W-1:0]        t;
    found = 0;
    for (int i = 0; i < len; i++) begin
      g = pick_grade(gen_thr);
      if (i < int'(MAX_RANKED) && g >= gen_thr) found++;
      t = TOTAL_W'($urandom);
      if (i == len - 1) begin
        case ($urandom_range(0, 7))
          0: t = '0;
          1: t = (found > 0) ? TOTAL_W'(found - 1) : TOTAL_W'($urandom);
          2: t = '1;
          3: t = TOTAL_W'($urandom);
          default: t = TOTAL_W'(found + int'($urandom_range(0, 8)));
        endcase
      end
      push_doc(g, i == len - 1, t, gap_max);
    end
  endtask

  // Wait until all queued documents are accepted and all results are back,
  // then let the block settle.
  task automatic wait_idle();
    while (doc_queue.size() != 0 || in_tvalid || ap_expected.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_threshold(input logic signed [GRADE_W-1:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    gen_thr = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Source: presents queued documents, idles per transaction, feeds the predictor.
  always @(posedge clk) begin : doc_source
    int unsigned gap;
    if (!rst_n) begin
      in_tvalid     <= 1'b0;
      src_wait      = 0;
      relevance_thr = 8'sd1;
      rank_cnt      = '0;
      rel_cnt       = '0;
      prec_sum      = '0;
    end else begin
      if (cfg_wr_en) relevance_thr = cfg_wr_data;
      if (!in_tvalid || in_tready) begin
        gap = src_wait;
        if (in_tvalid) begin
          score_document(cur_doc);
          gap = cur_doc.gap;
        end
        if (gap != 0) begin
          in_tvalid <= 1'b0;
          src_wait  = gap - 1;
        end else if (doc_queue.size() != 0) begin
          cur_doc = doc_queue.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {cur_doc.total, cur_doc.grade};
          in_tlast  <= cur_doc.last;
          src_wait  = 0;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Sink: random backpressure, compares each result transaction with the oldest prediction.
  always @(posedge clk) begin : result_sink
    ap_result_t  exp_r;
    int unsigned stall;
    if (!rst_n) begin
      out_tready <= 1'b0;
      sink_wait  = 0;
    end else begin
      stall = sink_wait;
      if (out_tvalid && out_tready) begin
        if (ap_expected.size() == 0) begin
          $display("%0t: result with none pending: tdata=%h tuser=%b",
                   $time, out_tdata, out_tuser);
          fail_count++;
        end else begin
          exp_r = ap_expected.pop_front();
          if (out_tdata[AP_W-1:0] !== exp_r.avg_prec) begin
            $display("%0t: average_precision expected %0d actual %0d",
                     $time, exp_r.avg_prec, out_tdata[AP_W-1:0]);
            fail_count++;
          end
          if (out_tdata[23:AP_W] !== '0) begin
            $display("%0t: tdata padding expected 0 actual %h", $time, out_tdata[23:AP_W]);
            fail_count++;
          end
          if (out_tuser[0] !== exp_r.defined) begin
            $display("%0t: result_defined expected %b actual %b",
                     $time, exp_r.defined, out_tuser[0]);
            fail_count++;
          end
          if (out_tuser[1] !== exp_r.saturated) begin
            $display("%0t: saturated expected %b actual %b",
                     $time, exp_r.saturated, out_tuser[1]);
            fail_count++;
          end
        end
        // occasionally switch between stall-free stretches and random stalls
        if ($urandom_range(0, 7) == 0) sink_burst = ($urandom_range(0, 2) == 0);
        stall = sink_burst ? 0 : $urandom_range(0, 6);
      end
      if (stall != 0) begin
        out_tready <= 1'b0;
        sink_wait  = stall - 1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    logic signed [GRADE_W-1:0] sweep [5];
    int                        count;
    int                        len;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed, reset threshold of 1
    push_doc(8'sd127, 1'b1, 16'd1, 6);               // single relevant doc, AP exactly 1.0
    push_doc(-8'sd128, 1'b1, 16'hFFFF, 6);           // nothing relevant -> undefined
    push_doc(8'sd1, 1'b0, 16'hFFFF, 6);              // grade equal to threshold
    push_doc(8'sd0, 1'b0, 16'd0, 6);
    push_doc(8'sd1, 1'b1, 16'd0, 6);                 // total of zero with hits -> clamp
    push_doc(8'sd0, 1'b0, 16'h5A5A, 6);
    push_doc(8'sd1, 1'b0, 16'hA5A5, 6);
    push_doc(8'sd1, 1'b0, 16'd7, 6);
    push_doc(-8'sd1, 1'b1, 16'hFFFF, 6);             // largest total, tiny AP
    push_doc(8'sd2, 1'b0, 16'd0, 0);
    push_doc(8'sd0, 1'b0, 16'd0, 0);
    push_doc(8'sd5, 1'b1, 16'd2, 0);                 // total equals found
    push_doc(8'sd1, 1'b0, 16'd1, 0);
    push_doc(8'sd1, 1'b0, 16'd1, 0);
    push_doc(8'sd1, 1'b1, 16'd2, 0);                 // total below found -> clamp
    push_doc(8'sd126, 1'b0, 16'd3, 3);
    push_doc(8'sd127, 1'b0, 16'd3, 3);
    push_doc(-8'sd1, 1'b1, 16'd3, 3);

    // random rankings over a threshold sweep; each phase ends on a last
    // document, and the sender holds until all results are back
    sweep[0] = 8'sd0;
    sweep[1] = -8'sd128;
    sweep[2] = 8'sd127;
    sweep[3] = -8'sd1;
    sweep[4] = GRADE_W'($urandom);
    foreach (sweep[p]) begin
      wait_idle();
      write_threshold(sweep[p]);
      count = 0;
      while (count < 180) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
        add_ranking(len, ($urandom_range(0, 3) == 0) ? 0 : 6);
        count += len;
      end
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #(64'd12_000_000);
    $display("Verification failed");
    $finish;
  end

endmodule
